// ===== hdl/noekeon_block_rounds_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Noekeon round pipeline
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef NOEKEON_BLOCK_ROUNDS_TOP_MACROS_SVH
`define NOEKEON_BLOCK_ROUNDS_TOP_MACROS_SVH

// same-cycle implication
`define NBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nbr assertion failed");

// next-cycle implication
`define NBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nbr assertion failed");

`endif

// ===== hdl/nbr_pkg.sv =====
// ----------------------------------------------------------------------------
// nbr_pkg
// Types, constants and round functions of the Noekeon round pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nbr_pkg;

   localparam int unsigned ROUNDS    = 16;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned RC_W      = 8;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [RC_W-1:0] RC_FWD_POLY = 8'h1B;
   localparam logic [RC_W-1:0] RC_BWD_POLY = 8'h8D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } nbr_csr_idx_type;

   typedef logic [WORD_W-1:0]                 nbr_word_type;
   typedef logic [3:0][WORD_W-1:0]            nbr_block_type;
   typedef logic [KEY_WORDS-1:0][WORD_W-1:0]  nbr_key_type;

   typedef struct packed {
      nbr_block_type   w;
      logic [RC_W-1:0] rc1;
      logic [RC_W-1:0] rc2;
   } nbr_stage_type;

   function automatic nbr_word_type nbr_rotl(nbr_word_type x, int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic nbr_word_type nbr_mix(nbr_word_type t);
      return t ^ nbr_rotl(t, 8) ^ nbr_rotl(t, 24);
   endfunction

   function automatic nbr_block_type nbr_theta(nbr_block_type b, nbr_key_type k);
      nbr_block_type w;
      nbr_word_type  t;
      w = b;
      t = nbr_mix(w[0] ^ w[2]);
      w[1] = w[1] ^ t;
      w[3] = w[3] ^ t;
      w[0] = w[0] ^ k[0];
      w[1] = w[1] ^ k[1];
      w[2] = w[2] ^ k[2];
      w[3] = w[3] ^ k[3];
      t = nbr_mix(w[1] ^ w[3]);
      w[0] = w[0] ^ t;
      w[2] = w[2] ^ t;
      return w;
   endfunction

   function automatic nbr_block_type nbr_gamma(nbr_block_type b);
      nbr_block_type w;
      nbr_word_type  t;
      w = b;
      w[1] = w[1] ^ (~w[3] & ~w[2]);
      w[0] = w[0] ^ (w[2] & w[1]);
      t    = w[3];
      w[3] = w[0];
      w[0] = t;
      w[2] = w[2] ^ w[0] ^ w[1] ^ w[3];
      w[1] = w[1] ^ (~w[3] & ~w[2]);
      w[0] = w[0] ^ (w[2] & w[1]);
      return w;
   endfunction

   // constant add, Theta, constant add: shared by rounds and the output step
   function automatic nbr_block_type nbr_core(nbr_stage_type s, nbr_key_type k);
      nbr_block_type w;
      w = s.w;
      w[0] = w[0] ^ {{(WORD_W-RC_W){1'b0}}, s.rc1};
      w = nbr_theta(w, k);
      w[0] = w[0] ^ {{(WORD_W-RC_W){1'b0}}, s.rc2};
      return w;
   endfunction

   function automatic logic [RC_W-1:0] nbr_rc_fwd(logic [RC_W-1:0] rc);
      return {rc[RC_W-2:0], 1'b0} ^ (rc[RC_W-1] ? RC_FWD_POLY : '0);
   endfunction

   function automatic logic [RC_W-1:0] nbr_rc_bwd(logic [RC_W-1:0] rc);
      return {1'b0, rc[RC_W-1:1]} ^ (rc[0] ? RC_BWD_POLY : '0);
   endfunction

   function automatic nbr_stage_type nbr_round(nbr_stage_type s, nbr_key_type k);
      nbr_stage_type r;
      nbr_block_type w;
      w = nbr_core(s, k);
      w[1] = nbr_rotl(w[1], 1);
      w[2] = nbr_rotl(w[2], 5);
      w[3] = nbr_rotl(w[3], 2);
      w = nbr_gamma(w);
      w[1] = nbr_rotl(w[1], 31);
      w[2] = nbr_rotl(w[2], 27);
      w[3] = nbr_rotl(w[3], 30);
      r.w   = w;
      r.rc1 = nbr_rc_fwd(s.rc1);
      r.rc2 = nbr_rc_bwd(s.rc2);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/nbr_if.sv =====
// ----------------------------------------------------------------------------
// nbr_req_if / nbr_rsp_if
// Valid/ready channels carrying blocks into and results out of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

interface nbr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] block_word0;
   logic [31:0] block_word1;
   logic [31:0] block_word2;
   logic [31:0] block_word3;
   logic [7:0]  rc1_start;
   logic [7:0]  rc2_start;

   modport source (output valid, block_word0, block_word1, block_word2, block_word3,
                   rc1_start, rc2_start, input ready);
   modport sink   (input valid, block_word0, block_word1, block_word2, block_word3,
                   rc1_start, rc2_start, output ready);
endinterface

interface nbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_word0;
   logic [31:0] result_word1;
   logic [31:0] result_word2;
   logic [31:0] result_word3;

   modport source (output valid, result_word0, result_word1, result_word2,
                   result_word3, input ready);
   modport sink   (input valid, result_word0, result_word1, result_word2,
                   result_word3, output ready);
endinterface

`default_nettype wire

// ===== hdl/nbr_round_cell.sv =====
// ----------------------------------------------------------------------------
// nbr_round_cell
// One Noekeon round with its own register stage and valid/ready hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "noekeon_block_rounds_top_macros.svh"

module nbr_round_cell
   import nbr_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  nbr_key_type   key,
   input  wire           up_valid,
   output logic          up_ready,
   input  nbr_stage_type up_data,
   output logic          dn_valid,
   input  wire           dn_ready,
   output nbr_stage_type dn_data
);

   logic          valid_ff, valid_in;
   nbr_stage_type data_ff;
   logic          load;

   // a cell takes a new item when empty or when its own item moves on
   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= nbr_round(up_data, key);
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   `NBR_ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !dn_ready, valid_ff && $stable(data_ff))
   `NBR_ASSERT_NOW(a_empty_ready, clock, reset, !valid_ff, up_ready)
   `NBR_ASSERT_NEXT(a_take_fills, clock, reset, up_valid && up_ready, valid_ff)

endmodule

`default_nettype wire

// ===== hdl/nbr_final_stage.sv =====
// ----------------------------------------------------------------------------
// nbr_final_stage
// Closing constant/Theta/constant step and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nbr_final_stage
   import nbr_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  nbr_key_type   key,
   input  wire           up_valid,
   output logic          up_ready,
   input  nbr_stage_type up_data,
   nbr_rsp_if.source     rsp_if
);

   logic          valid_ff, valid_in;
   nbr_block_type data_ff;
   logic          load;

   assign up_ready = !valid_ff || rsp_if.ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= nbr_core(up_data, key);
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.result_word0 = data_ff[0];
   assign rsp_if.result_word1 = data_ff[1];
   assign rsp_if.result_word2 = data_ff[2];
   assign rsp_if.result_word3 = data_ff[3];

endmodule

`default_nettype wire

// ===== hdl/noekeon_block_rounds_top.sv =====
// ----------------------------------------------------------------------------
// noekeon_block_rounds_top
// Fully unrolled Noekeon 128-bit round pipeline with a CSR-loaded key.
// ----------------------------------------------------------------------------
// Each item is a 128-bit block plus the two starting round constants. It passes
// through a row of ROUNDS round cells, each one register stage, and then the
// output stage that applies the closing constant/Theta/constant step. One item
// is accepted every cycle until backpressure fills all stages, set by the
// one-round-per-stage row of cells. Every stage holds its item under backpressure
// while empty stages upstream keep filling, so input keeps flowing while a result
// waits until every stage is full. The four key words are csr registers read by
// all stages directly; write them only while no item is in flight. Encryption or
// decryption is chosen by the caller through the constants and key prepared.
`default_nettype none

module noekeon_block_rounds_top
   import nbr_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   nbr_req_if.sink              req_if,
   nbr_rsp_if.source            rsp_if,
   input  wire                  csr_write_en,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [WORD_W-1:0]     csr_write_data
);

   nbr_key_type   key_ff, key_in;
   nbr_stage_type stage_data  [0:ROUNDS];
   logic          stage_valid [0:ROUNDS];
   logic          stage_ready [0:ROUNDS];

   always_comb begin
      key_in = key_ff;
      if (csr_write_en) begin
         case (nbr_csr_idx_type'(csr_index))
            CSR_KEY_WORD0: key_in[0] = csr_write_data;
            CSR_KEY_WORD1: key_in[1] = csr_write_data;
            CSR_KEY_WORD2: key_in[2] = csr_write_data;
            CSR_KEY_WORD3: key_in[3] = csr_write_data;
            default:       key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign stage_valid[0]  = req_if.valid;
   assign req_if.ready    = stage_ready[0];
   assign stage_data[0].w = {req_if.block_word3, req_if.block_word2,
                             req_if.block_word1, req_if.block_word0};
   assign stage_data[0].rc1 = req_if.rc1_start;
   assign stage_data[0].rc2 = req_if.rc2_start;

   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      nbr_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .key      (key_ff),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_data  (stage_data[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_data  (stage_data[i+1])
      );
   end

   nbr_final_stage u_final (
      .clock    (clock),
      .reset    (reset),
      .key      (key_ff),
      .up_valid (stage_valid[ROUNDS]),
      .up_ready (stage_ready[ROUNDS]),
      .up_data  (stage_data[ROUNDS]),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// ===== tb/nbr_scoreboard.sv =====
// ----------------------------------------------------------------------------
// nbr_scoreboard
// Watches the block and key channels of the Noekeon round pipeline, computes
// the expected result block for every accepted item and compares it with the
// results in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module nbr_scoreboard
   import nbr_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   nbr_req_if                   req_mon,
   nbr_rsp_if                   rsp_mon,
   input  wire                  csr_write_en,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [WORD_W-1:0]     csr_write_data,
   output int                   fail_count,
   output int                   pending_results
);

   nbr_key_type   key_copy;
   nbr_block_type expected_blocks[$];

   function automatic nbr_word_type rot_left(nbr_word_type x, int unsigned n);
      int unsigned s;
      s = n % WORD_W;
      if (s == 0) return x;
      return (x << s) | (x >> (WORD_W - s));
   endfunction

   function automatic nbr_word_type spread(nbr_word_type t);
      return t ^ rot_left(t, 8) ^ rot_left(t, 24);
   endfunction

   function automatic nbr_block_type theta_mix(nbr_block_type b, nbr_key_type k);
      nbr_block_type w;
      nbr_word_type  t;
      w = b;
      t = spread(w[0] ^ w[2]);
      w[1] ^= t;
      w[3] ^= t;
      for (int i = 0; i < 4; i++) w[i] ^= k[i];
      t = spread(w[1] ^ w[3]);
      w[0] ^= t;
      w[2] ^= t;
      return w;
   endfunction

   // ROUNDS full rounds, then the closing constant/Theta/constant step
   function automatic nbr_block_type noekeon_rounds(nbr_block_type blk,
                                                    logic [RC_W-1:0] rc1_in,
                                                    logic [RC_W-1:0] rc2_in,
                                                    nbr_key_type k);
      nbr_block_type   w;
      nbr_word_type    t;
      logic [RC_W-1:0] fwd;
      logic [RC_W-1:0] bwd;
      w   = blk;
      fwd = rc1_in;
      bwd = rc2_in;
      for (int r = 0; r < ROUNDS; r++) begin
         w[0] ^= {24'd0, fwd};
         w = theta_mix(w, k);
         w[0] ^= {24'd0, bwd};
         w[1] = rot_left(w[1], 1);
         w[2] = rot_left(w[2], 5);
         w[3] = rot_left(w[3], 2);
         // nonlinear layer
         w[1] ^= ~w[3] & ~w[2];
         w[0] ^= w[2] & w[1];
         t    = w[3];
         w[3] = w[0];
         w[0] = t;
         w[2] ^= w[0] ^ w[1] ^ w[3];
         w[1] ^= ~w[3] & ~w[2];
         w[0] ^= w[2] & w[1];
         w[1] = rot_left(w[1], 31);
         w[2] = rot_left(w[2], 27);
         w[3] = rot_left(w[3], 30);
         fwd = fwd[7] ? ({fwd[6:0], 1'b0} ^ 8'h1B) : {fwd[6:0], 1'b0};
         bwd = bwd[0] ? ({1'b0, bwd[7:1]} ^ 8'h8D) : {1'b0, bwd[7:1]};
      end
      w[0] ^= {24'd0, fwd};
      w = theta_mix(w, k);
      w[0] ^= {24'd0, bwd};
      return w;
   endfunction

   task automatic report_mismatch(string what, nbr_word_type got, nbr_word_type want);
      $display("MISMATCH %s: got %08h, expected %08h", what, got, want);
      fail_count = fail_count + 1;
   endtask

   initial begin
      fail_count      = 0;
      pending_results = 0;
      key_copy        = '0;
   end

   always @(posedge clock) begin
      nbr_block_type blk;
      nbr_block_type want;
      if (reset) begin
         key_copy = '0;
         expected_blocks.delete();
      end else begin
         if (csr_write_en === 1'b1) begin
            case (nbr_csr_idx_type'(csr_index))
               CSR_KEY_WORD0: key_copy[0] = csr_write_data;
               CSR_KEY_WORD1: key_copy[1] = csr_write_data;
               CSR_KEY_WORD2: key_copy[2] = csr_write_data;
               CSR_KEY_WORD3: key_copy[3] = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            blk[0] = req_mon.block_word0;
            blk[1] = req_mon.block_word1;
            blk[2] = req_mon.block_word2;
            blk[3] = req_mon.block_word3;
            expected_blocks.push_back(noekeon_rounds(blk, req_mon.rc1_start,
                                                     req_mon.rc2_start, key_copy));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected item", rsp_mon.result_word0, '0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_mon.result_word0 !== want[0])
                  report_mismatch("result_word0", rsp_mon.result_word0, want[0]);
               if (rsp_mon.result_word1 !== want[1])
                  report_mismatch("result_word1", rsp_mon.result_word1, want[1]);
               if (rsp_mon.result_word2 !== want[2])
                  report_mismatch("result_word2", rsp_mon.result_word2, want[2]);
               if (rsp_mon.result_word3 !== want[3])
                  report_mismatch("result_word3", rsp_mon.result_word3, want[3]);
            end
         end
      end
      pending_results <= expected_blocks.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Noekeon round pipeline: directed corner blocks, then
// random blocks under several key settings and idle/stall mixes, plus a long
// result hold-off that backs up the pipeline. The scoreboard does the checks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import nbr_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 290;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_write_data;
   logic                 hold_trigger;
   int                   fail_count;
   int                   pending_results;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   int                   cycle_count;

   nbr_req_if req_bus();
   nbr_rsp_if rsp_bus();

   noekeon_block_rounds_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   nbr_scoreboard i_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on each trigger toggle
   initial begin : receiver
      int hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger !== hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_block(nbr_block_type blk, logic [RC_W-1:0] rc1,
                             logic [RC_W-1:0] rc2);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.block_word0 <= blk[0];
      req_bus.block_word1 <= blk[1];
      req_bus.block_word2 <= blk[2];
      req_bus.block_word3 <= blk[3];
      req_bus.rc1_start   <= rc1;
      req_bus.rc2_start   <= rc2;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   // stop offering items and wait for the pipeline to empty
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(nbr_key_type k);
      nbr_csr_idx_type idx [4];
      idx = '{CSR_KEY_WORD0, CSR_KEY_WORD1, CSR_KEY_WORD2, CSR_KEY_WORD3};
      for (int i = 0; i < 4; i++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= idx[i];
         csr_write_data <= k[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic nbr_word_type rand_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h0000_00FF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [RC_W-1:0] rand_rc();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h01;
         default: return RC_W'($urandom());
      endcase
   endfunction

   task automatic send_random(int count);
      nbr_block_type blk;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 4; i++) blk[i] = rand_word();
         send_block(blk, rand_rc(), rand_rc());
      end
   endtask

   initial begin : stimulus
      nbr_block_type blk;
      nbr_key_type   k;
      int            stall_mix [4][2];
      stall_mix = '{'{0, 0}, '{61, 0}, '{0, 61}, '{10, 10}};
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          <= 1'b1;
      hold_trigger   <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_KEY_WORD0;
      csr_write_data <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.block_word0 <= '0;
      req_bus.block_word1 <= '0;
      req_bus.block_word2 <= '0;
      req_bus.block_word3 <= '0;
      req_bus.rc1_start   <= '0;
      req_bus.rc2_start   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items with the reset key
      send_block('0, 8'h00, 8'h00);
      send_block('1, 8'hFF, 8'hFF);
      send_block('0, 8'h80, 8'h01);
      send_block('1, 8'h01, 8'h80);
      send_block('0, 8'h80, 8'h00);   // usual encrypt constants
      send_block('0, 8'h00, 8'hD4);   // usual decrypt constants
      for (int i = 0; i < 8; i++) begin
         blk = '0;
         blk[i / 2] = (i % 2) ? 32'h8000_0000 : 32'h0000_0001;
         send_block(blk, 8'h1B, 8'h8D);
      end
      for (int i = 0; i < 4; i++) begin
         blk = '1;
         blk[i] = '0;
         send_block(blk, 8'h7F, 8'hFE);
      end
      send_block({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210},
                 8'h55, 8'hAA);
      drain_pipeline();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       k = '1;
            2:       k = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000};
            default: for (int i = 0; i < 4; i++) k[i] = $urandom();
         endcase
         load_key(k);
         send_idle_pct  = stall_mix[p][0];
         recv_stall_pct = stall_mix[p][1];
         send_random(PHASE_ITEMS);
         drain_pipeline();
      end

      // hold results back while items keep coming, so the input stalls
      load_key('0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_trigger  <= ~hold_trigger;
      send_random(60);
      drain_pipeline();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
